FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define M4I_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define M4I_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

FILE: rtl/m4i_pkg.sv
`timescale 1ns / 1ps

package m4i_pkg;

    localparam int ELEM_W        = 32;
    localparam int IDX_W         = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MINOR_W       = 99;   // exact 3x3 minor
    localparam int DET_W         = 133;  // exact determinant
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              done;
        logic [ELEM_W-1:0] quotient;
    } div_status_t;

    // i-th index (0..2) left after removing index sk from 0..3
    function automatic logic [1:0] skip_idx(input logic [1:0] idx, input logic [1:0] sk);
        return (idx >= sk) ? idx + 2'd1 : idx;
    endfunction

endpackage

FILE: rtl/m4i_ram.sv
`timescale 1ns / 1ps

module m4i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/m4i_div.sv
`timescale 1ns / 1ps

module m4i_div #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [m4i_pkg::MINOR_W-1:0]  num,
    input  logic                         num_neg,
    input  logic [m4i_pkg::DET_W-1:0]    den,
    output m4i_pkg::div_status_t         status
);

    localparam int SHIFT = 2 * FRAC_BITS;
    localparam int MW    = m4i_pkg::MINOR_W;
    localparam int DW    = m4i_pkg::DET_W;
    localparam int UW    = (DW + 33 > MW + SHIFT) ? DW + 33 : MW + SHIFT;

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_DONE} state_t;

    state_t                      state_reg;
    logic [UW-1:0]               rem_reg;
    logic [UW-1:0]               dsh_reg;
    logic [DW-1:0]               dabs_reg;
    logic [m4i_pkg::ELEM_W-1:0]  q_reg;
    logic [4:0]                  cnt_reg;
    logic                        neg_reg;
    logic                        big_reg;

    logic [MW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [UW-1:0] dabs_ext;

    assign num_mag  = num[MW-1] ? (~num + 1'b1) : num;
    assign den_mag  = den[DW-1] ? (~den + 1'b1) : den;
    assign dabs_ext = {{(UW-DW){1'b0}}, dabs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        rem_reg   <= {{(UW-MW){1'b0}}, num_mag} << SHIFT;
                        dabs_reg  <= den_mag;
                        neg_reg   <= num[MW-1] ^ num_neg ^ den[DW-1];
                        state_reg <= D_CHK;
                    end
                end
                D_CHK: begin
                    // quotient of 2^32 or more saturates whatever the sign
                    big_reg   <= rem_reg >= (dabs_ext << 32);
                    dsh_reg   <= dabs_ext << 31;
                    cnt_reg   <= 5'd31;
                    q_reg     <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN: begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[30:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[30:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= D_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                D_DONE: begin
                    state_reg <= D_IDLE;
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        status.done = (state_reg == D_DONE);
        if (neg_reg) begin
            status.quotient = (big_reg || q_reg > m4i_pkg::SAT_MIN) ? m4i_pkg::SAT_MIN
                                                                   : (~q_reg + 1'b1);
        end else begin
            status.quotient = (big_reg || q_reg[31]) ? m4i_pkg::SAT_MAX : q_reg;
        end
    end

endmodule

FILE: rtl/m4i_front.sv
`timescale 1ns / 1ps

module m4i_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [m4i_pkg::ELEM_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        q_valid,
    output m4i_pkg::item_t              q_item,
    input  logic                        q_ready
);

    localparam int AW = m4i_pkg::QUEUE_AW;
    localparam logic [AW:0] FULL_COUNT = (AW + 1)'(m4i_pkg::QUEUE_DEPTH);

    m4i_pkg::item_t  fifo_reg [m4i_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            push;
    logic            pop;

    assign s_axis_tready = (count_reg != FULL_COUNT);
    assign q_valid       = (count_reg != '0);
    assign q_item        = fifo_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg].element <= s_axis_tdata;
            fifo_reg[wr_ptr_reg].last    <= s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/m4i_back.sv
`timescale 1ns / 1ps

module m4i_back #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  m4i_pkg::item_t                   q_item,
    output logic                             q_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [m4i_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int EW = m4i_pkg::ELEM_W;
    localparam int MW = m4i_pkg::MINOR_W;
    localparam int DW = m4i_pkg::DET_W;

    typedef enum logic [2:0] {
        S_LOAD, S_RD, S_LD, S_MUL, S_ACC, S_DSTART, S_DWAIT, S_OUT
    } state_t;

    typedef enum logic [1:0] {TERM_P, TERM_Q, TERM_R} term_t;

    state_t          state_reg;
    term_t           term_reg;
    logic [3:0]      load_cnt_reg;
    logic [3:0]      min_reg;
    logic [1:0]      k_reg;
    logic [1:0]      limb_reg;
    logic            det_phase_reg;
    logic [3:0]      oidx_reg;
    logic [MW-1:0]   x_reg;
    logic [EW-1:0]   e_reg;
    logic [64:0]     prod_reg;
    logic [MW-1:0]   acc2_reg;
    logic [MW-1:0]   accm_reg;
    logic [DW-1:0]   det_reg;
    logic [MW-1:0]   minor_reg [16];
    logic            out_valid_reg;
    logic [EW-1:0]   out_val_reg;
    logic [3:0]      out_idx_reg;
    logic            out_sing_reg;
    logic            out_last_reg;

    logic [3:0]      addr_a;
    logic [3:0]      addr_b;
    logic [EW-1:0]   ram_a;
    logic [EW-1:0]   ram_b;
    logic            ram_we;
    logic [32:0]     limb_op;
    logic [DW-1:0]   addend;
    logic [DW-1:0]   target;
    logic [DW-1:0]   sum;
    logic            sub;
    logic [3:0]      minor_raddr;
    logic [MW-1:0]   minor_rd;
    logic            det_zero;
    logic            div_start;
    m4i_pkg::div_status_t div_st;

    // element fetch for the current term
    always_comb begin
        logic [1:0] sr, sc, rs0, rs1, rs2, ca, cb, csa, csb, csk;
        sr  = min_reg[3:2];
        sc  = min_reg[1:0];
        rs0 = m4i_pkg::skip_idx(2'd0, sr);
        rs1 = m4i_pkg::skip_idx(2'd1, sr);
        rs2 = m4i_pkg::skip_idx(2'd2, sr);
        ca  = (k_reg == 2'd0) ? 2'd1 : 2'd0;
        cb  = (k_reg == 2'd2) ? 2'd1 : 2'd2;
        csa = m4i_pkg::skip_idx(ca, sc);
        csb = m4i_pkg::skip_idx(cb, sc);
        csk = m4i_pkg::skip_idx(k_reg, sc);
        addr_a = {rs1, csa};
        addr_b = {rs2, csb};
        if (det_phase_reg) begin
            addr_b = {2'b00, min_reg[1:0]};
        end else begin
            case (term_reg)
                TERM_P: addr_b = {rs2, csb};
                TERM_Q: begin
                    addr_a = {rs1, csb};
                    addr_b = {rs2, csa};
                end
                TERM_R: addr_b = {rs0, csk};
                default: addr_b = {rs2, csb};
            endcase
        end
    end

    assign ram_we = (state_reg == S_LOAD) && q_valid;
    assign q_ready = (state_reg == S_LOAD);

    m4i_ram #(
        .WIDTH (EW),
        .DEPTH (16)
    ) u_src (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (load_cnt_reg),
        .wdata   (q_item.element),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // 32-bit limbs, low three unsigned, top one the signed remaining 3 bits
    always_comb begin
        case (limb_reg)
            2'd0:    limb_op = {1'b0, x_reg[31:0]};
            2'd1:    limb_op = {1'b0, x_reg[63:32]};
            2'd2:    limb_op = {1'b0, x_reg[95:64]};
            default: limb_op = {{30{x_reg[MW-1]}}, x_reg[MW-1:96]};
        endcase
    end

    always_comb begin
        addend = {{(DW-65){prod_reg[64]}}, prod_reg} << {limb_reg, 5'b00000};
        if (det_phase_reg) begin
            target = det_reg;
            sub    = min_reg[0];
        end else if (term_reg == TERM_R) begin
            target = {{(DW-MW){accm_reg[MW-1]}}, accm_reg};
            sub    = (k_reg == 2'd1);
        end else begin
            target = {{(DW-MW){acc2_reg[MW-1]}}, acc2_reg};
            sub    = (term_reg == TERM_Q);
        end
        sum = sub ? target - addend : target + addend;
    end

    // adjugate entry (i,j) is the cofactor of (j,i)
    assign minor_raddr = (state_reg == S_DSTART) ? {oidx_reg[1:0], oidx_reg[3:2]} : min_reg;
    assign minor_rd    = minor_reg[minor_raddr];
    assign det_zero    = (det_reg == '0);
    assign div_start   = (state_reg == S_DSTART) && !det_zero;

    m4i_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (minor_rd),
        .num_neg (oidx_reg[2] ^ oidx_reg[0]),
        .den     (det_reg),
        .status  (div_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            det_phase_reg <= 1'b0;
            term_reg      <= TERM_P;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (q_valid) begin
                        if (q_item.last) begin
                            load_cnt_reg  <= '0;
                            min_reg       <= '0;
                            k_reg         <= '0;
                            limb_reg      <= '0;
                            term_reg      <= TERM_P;
                            det_phase_reg <= 1'b0;
                            acc2_reg      <= '0;
                            accm_reg      <= '0;
                            det_reg       <= '0;
                            state_reg     <= S_RD;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 4'd1;
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_LD;
                end
                S_LD: begin
                    if (det_phase_reg) begin
                        x_reg <= minor_rd;
                    end else if (term_reg == TERM_R) begin
                        x_reg <= acc2_reg;
                    end else begin
                        x_reg <= {{(MW-EW){ram_a[EW-1]}}, ram_a};
                    end
                    e_reg     <= ram_b;
                    limb_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= 65'($signed(limb_op) * $signed(e_reg));
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (det_phase_reg) begin
                        det_reg <= sum;
                    end else if (term_reg == TERM_R) begin
                        // last limb of the last term: minor done, clear for the next
                        accm_reg <= (limb_reg == 2'd3 && k_reg == 2'd2) ? '0 : sum[MW-1:0];
                    end else begin
                        acc2_reg <= sum[MW-1:0];
                    end
                    if (limb_reg != 2'd3) begin
                        limb_reg  <= limb_reg + 2'd1;
                        state_reg <= S_MUL;
                    end else begin
                        limb_reg  <= '0;
                        if (det_phase_reg) begin
                            if (min_reg[1:0] == 2'd3) begin
                                oidx_reg  <= '0;
                                state_reg <= S_DSTART;
                            end else begin
                                min_reg   <= min_reg + 4'd1;
                                state_reg <= S_RD;
                            end
                        end else begin
                            state_reg <= S_RD;
                            case (term_reg)
                                TERM_P: term_reg <= TERM_Q;
                                TERM_Q: term_reg <= TERM_R;
                                TERM_R: begin
                                    term_reg <= TERM_P;
                                    acc2_reg <= '0;
                                    if (k_reg != 2'd2) begin
                                        k_reg <= k_reg + 2'd1;
                                    end else begin
                                        k_reg              <= '0;
                                        minor_reg[min_reg] <= sum[MW-1:0];
                                        if (min_reg == 4'd15) begin
                                            det_phase_reg <= 1'b1;
                                            min_reg       <= '0;
                                        end else begin
                                            min_reg <= min_reg + 4'd1;
                                        end
                                    end
                                end
                                default: term_reg <= TERM_P;
                            endcase
                        end
                    end
                end
                S_DSTART: begin
                    out_idx_reg  <= oidx_reg;
                    out_last_reg <= (oidx_reg == 4'd15);
                    if (det_zero) begin
                        out_val_reg   <= '0;
                        out_sing_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_st.done) begin
                        out_val_reg   <= div_st.quotient;
                        out_sing_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        out_valid_reg <= 1'b0;
                        if (oidx_reg == 4'd15) begin
                            state_reg <= S_LOAD;
                        end else begin
                            oidx_reg  <= oidx_reg + 4'd1;
                            state_reg <= S_DSTART;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_idx_reg, out_val_reg};
    assign m_axis_tuser  = out_sing_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/matrix4_inverse.sv
`timescale 1ns / 1ps

// 4x4 matrix inverse by adjugate, signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default). Send the sixteen elements row-major, one a beat,
// with tlast on the sixteenth; the block returns sixteen beats of the
// inverse, row-major, each quotient truncated towards zero and saturated to
// 32 bits. A zero determinant gives sixteen zero beats with tuser set. An
// early tlast inverts the store as it stands; a run without tlast wraps and
// overwrites from position 0. Each element goes through a four-deep queue
// into the source store. The inversion then runs on one shared 33x32
// multiplier, each product term taking a fetch, a load and four limb
// multiply/accumulate pairs: 144 terms for the sixteen minors and 4 for the
// determinant. Each result then takes a start step, the radix-2 divider (one
// range check, 32 quotient bits, one finish step) and a step to hand over the
// beat. New elements queue meanwhile, up to four deep.

`include "assert_macros.svh"

module matrix4_inverse #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] matrix_element
    input  logic [m4i_pkg::ELEM_W-1:0]       s_axis_tdata,
    input  logic                             s_axis_tlast,      // last_element
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] inverse_element, [35:32] element_index, [39:36] zero
    output logic [m4i_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] singular
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast       // last_result
);

    logic           q_valid;
    logic           q_ready;
    m4i_pkg::item_t q_item;

    // Front: accepts beats into a short queue.
    m4i_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready)
    );

    // Back: loads the store, runs the inversion, holds each result beat.
    m4i_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // the store is never loaded while a result beat is pending
    `M4I_ASSERT_NEVER(a_no_load_during_out, aclk, aresetn, m_axis_tvalid && q_ready, "load while result pending")
    // the final beat carries index fifteen
    `M4I_ASSERT_IMPL(a_last_index, aclk, aresetn, m_axis_tvalid && m_axis_tlast, m_axis_tdata[35:32] == 4'hF, "tlast on wrong index")
    // singular results are zero
    `M4I_ASSERT_IMPL(a_sing_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == '0, "singular beat not zero")

endmodule

FILE: tb/matrix4_inverse_checker.sv
`timescale 1ns / 1ps

module matrix4_inverse_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [m4i_pkg::ELEM_W-1:0]      s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [m4i_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            m_axis_tlast,
    output int                              fail_count,
    output int                              beats_pending
);

    localparam int FB = m4i_pkg::FRAC_BITS_DEF;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        last;
    } inv_beat_t;

    logic [31:0] src_store [16];
    logic [3:0]  load_pos;
    inv_beat_t   inverse_q[$];

    function automatic wide_t elem_at(input int r, input int c);
        wide_t v;
        v = $signed(src_store[r * 4 + c]);
        return v;
    endfunction

    // 3x3 minor with row sr and column sc struck out, exact
    function automatic wide_t minor_of(input int sr, input int sc);
        int    rs[3];
        int    cs[3];
        int    n;
        wide_t a[3][3];
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sr) begin rs[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sc) begin cs[n] = k; n++; end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = elem_at(rs[i], cs[j]);
        return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
             - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
             + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    endfunction

    // adjugate over determinant, truncated towards zero, clamped to 32 bits
    task automatic predict_inverse();
        wide_t     mn[4][4];
        wide_t     det;
        wide_t     num;
        wide_t     quo;
        logic      sing;
        inv_beat_t b;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                mn[r][c] = minor_of(r, c);
        det = 0;
        for (int c = 0; c < 4; c++)
            if (c & 1) det = det - elem_at(0, c) * mn[0][c];
            else       det = det + elem_at(0, c) * mn[0][c];
        sing = (det == 0);
        for (int k = 0; k < 16; k++) begin
            b.value = '0;
            if (!sing) begin
                num = mn[k & 3][k >> 2];
                if (((k >> 2) + (k & 3)) & 1) num = -num;
                num = num <<< (2 * FB);
                quo = num / det;
                if (quo > 192'sh7FFF_FFFF)
                    b.value = m4i_pkg::SAT_MAX;
                else if (quo < -(192'sh8000_0000))
                    b.value = m4i_pkg::SAT_MIN;
                else
                    b.value = quo[31:0];
            end
            b.index    = 4'(k);
            b.singular = sing;
            b.last     = (k == 15);
            inverse_q.push_back(b);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        inv_beat_t e;
        if (!aresetn) begin
            load_pos      <= '0;
            fail_count    = 0;
            beats_pending = 0;
            inverse_q.delete();
            for (int i = 0; i < 16; i++) src_store[i] = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = inverse_q.pop_front();
                    check_field("inverse_element", e.value, m_axis_tdata[31:0]);
                    check_field("element_index", 32'(e.index), 32'(m_axis_tdata[35:32]));
                    check_field("singular", 32'(e.singular), 32'(m_axis_tuser));
                    check_field("last_result", 32'(e.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                src_store[load_pos] = s_axis_tdata;
                if (s_axis_tlast) begin
                    predict_inverse();
                    load_pos <= '0;
                end else begin
                    load_pos <= load_pos + 4'd1;
                end
            end
            beats_pending = inverse_q.size();
        end
    end

endmodule

FILE: tb/matrix4_inverse_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 4x4 inverse; the checker alongside predicts
// and compares every result beat.
module matrix4_inverse_tb;

    localparam int    CYCLE_LIMIT = 3_000_000; // ~30 matrices, stalls, hold-off
    localparam logic [31:0] ONE   = 32'h0001_0000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // [31:0] matrix_element
    logic        s_axis_tlast;  // last_element
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;  // [31:0] inverse_element, [35:32] element_index, [39:36] zero
    logic        m_axis_tuser;  // [0] singular
    logic        m_axis_tlast;  // last_result

    int          fail_count;
    int          beats_pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        holding;
    int          cycle_cnt;
    logic [31:0] mat [16];

    matrix4_inverse dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    matrix4_inverse_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // receiver: random stalls, forced low during the hold-off
    always @(posedge aclk) begin
        if (holding) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long hold-off early in the run while the sender keeps going: the input
    // queue fills and tready must drop
    initial begin
        holding = 1'b0;
        wait (aresetn);
        repeat (300) @(posedge aclk);
        holding <= 1'b1;
        repeat (9000) @(posedge aclk);
        holding <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one element beat; optional idle gap before it
    task automatic send_beat(input logic [31:0] val, input logic lst);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tlast  <= lst;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // len beats taken cyclically from mat, tlast on the final one
    task automatic send_matrix(input int len);
        for (int i = 0; i < len; i++)
            send_beat(mat[i % 16], i == len - 1);
    endtask

    task automatic set_diag(input logic [31:0] d0, input logic [31:0] d1,
                            input logic [31:0] d2, input logic [31:0] d3);
        for (int i = 0; i < 16; i++) mat[i] = '0;
        mat[0] = d0; mat[5] = d1; mat[10] = d2; mat[15] = d3;
    endtask

    // small Q16.16 value, roughly within +-8.0
    function automatic logic [31:0] small_val();
        return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    task automatic random_matrix();
        int kind;
        int len;
        int r;
        kind = $urandom_range(0, 9);
        len  = 16;
        for (int i = 0; i < 16; i++)
            case (kind)
                0, 1:    mat[i] = $urandom();
                2:       mat[i] = {16'($signed($urandom_range(0, 16)) - 8), 16'h0};
                default: mat[i] = small_val();
            endcase
        if (kind == 3) begin
            // singular: one row duplicates another
            r = $urandom_range(1, 3);
            for (int c = 0; c < 4; c++) mat[r * 4 + c] = mat[c];
        end
        if (kind == 4) len = $urandom_range(1, 15);   // early tlast
        if (kind == 5) len = $urandom_range(17, 24);  // overrun wraps
        send_matrix(len);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_cnt      = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, zero (singular), mixed diagonal, saturation both
        // ways, extreme values, early tlast, overrun
        set_diag(ONE, ONE, ONE, ONE);
        send_matrix(16);
        set_diag('0, '0, '0, '0);
        send_matrix(16);
        set_diag(32'h0002_0000, 32'hFFFF_8000, 32'h0004_0000, 32'hFFF8_0000);
        send_matrix(16);
        set_diag(32'h0000_0001, 32'hFFFF_FFFF, ONE, ONE);
        send_matrix(16);
        for (int i = 0; i < 16; i++)
            mat[i] = (i % 5 == 0) ? 32'h7FFF_FFFF : ((i % 3 == 0) ? 32'h8000_0000 : i);
        send_matrix(16);
        set_diag(ONE, 32'h0003_0000, ONE, ONE);
        send_matrix(3);
        send_matrix(20);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int m = 0; m < 5; m++) random_matrix();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (beats_pending != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
